### rtl/rational_fraction_alu_macros.svh
// Assertion macros for the rational fraction ALU.
// Used by the top level only; needs nothing else.
`ifndef RATIONAL_FRACTION_ALU_MACROS_SVH
`define RATIONAL_FRACTION_ALU_MACROS_SVH

// same-cycle implication
`define RFA_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RFA_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rfa_pkg.sv
// Shared types and codes for the rational fraction ALU.
// No dependencies; used by rfa_unit, rational_fraction_alu and the testbench.
`timescale 1ns / 1ps

package rfa_pkg;

	localparam logic [1:0] K_ADD = 2'd0;
	localparam logic [1:0] K_SUB = 2'd1;
	localparam logic [1:0] K_MUL = 2'd2;
	localparam logic [1:0] K_DIV = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_DEN  = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam int DIV_NARROW = 32;
	localparam int DIV_WIDE   = 64;

	typedef enum logic [2:0] {
		UOP_GCD = 3'b001,
		UOP_DIV = 3'b010,
		UOP_MUL = 3'b100
	} uop_t;

	typedef struct packed {
		logic start;
		uop_t op;
		logic wide;   // 64-step divide; 32-step otherwise
	} unit_cmd_t;

	typedef struct packed {
		logic done;
		logic busy;
	} unit_rsp_t;

endpackage

### rtl/rfa_unit.sv
// Shared arithmetic unit: binary GCD, restoring divide, 32x32 multiply.
// One step per cycle. Depends on rfa_pkg.
`timescale 1ns / 1ps

module rfa_unit import rfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  unit_cmd_t   cmd,
	input  logic [63:0] opa,
	input  logic [63:0] opb,
	output unit_rsp_t   rsp,
	output logic [63:0] result
);

	typedef enum logic [6:0] {
		U_IDLE = 7'b0000001,
		U_TWO  = 7'b0000010,
		U_AODD = 7'b0000100,
		U_LOOP = 7'b0001000,
		U_FIX  = 7'b0010000,
		U_DIV  = 7'b0100000,
		U_MUL  = 7'b1000000
	} ustate_t;

	ustate_t     state_q;
	logic        done_q;
	logic [5:0]  k_q;
	logic [6:0]  cnt_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] rem_q;

	logic [64:0] trial;
	logic [64:0] sub;
	logic        ge;
	logic [63:0] prod;

	assign trial = {rem_q, a_q[63]};
	assign sub   = trial - {1'b0, b_q};
	assign ge    = trial >= {1'b0, b_q};
	assign prod  = {32'b0, a_q[31:0]} * {32'b0, b_q[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
			cnt_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (cmd.start) begin
						b_q   <= opb;
						rem_q <= '0;
						k_q   <= '0;
						case (cmd.op)
							UOP_GCD: begin
								a_q     <= opa;
								state_q <= U_TWO;
							end
							UOP_DIV: begin
								// narrow divide: dividend bits enter from the top
								a_q     <= cmd.wide ? opa : {opa[31:0], 32'b0};
								cnt_q   <= cmd.wide ? 7'(DIV_WIDE) : 7'(DIV_NARROW);
								state_q <= U_DIV;
							end
							UOP_MUL: begin
								a_q     <= opa;
								state_q <= U_MUL;
							end
							default: state_q <= U_IDLE;
						endcase
					end
				end
				U_TWO: begin
					if (a_q[0] | b_q[0]) begin
						state_q <= U_AODD;
					end else begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + 6'd1;
					end
				end
				U_AODD: begin
					if (a_q[0]) begin
						state_q <= U_LOOP;
					end else begin
						a_q <= a_q >> 1;
					end
				end
				U_LOOP: begin
					// a stays odd; b shrinks to zero
					if (b_q == '0) begin
						state_q <= U_FIX;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_q > b_q) begin
						a_q <= b_q;
						b_q <= a_q - b_q;
					end else begin
						b_q <= b_q - a_q;
					end
				end
				U_FIX: begin
					if (k_q == '0) begin
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end else begin
						a_q <= a_q << 1;
						k_q <= k_q - 6'd1;
					end
				end
				U_DIV: begin
					a_q   <= {a_q[62:0], ge};
					rem_q <= ge ? sub[63:0] : trial[63:0];
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end
				end
				U_MUL: begin
					a_q     <= prod;
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = (state_q != U_IDLE);
	assign result   = a_q;

endmodule

### rtl/rational_fraction_alu.sv
// Rational fraction ALU: add/sub/mul/div of two fractions, result in lowest terms.
// A bad denominator goes from accept straight to the final state and on to the output
// register; other items run the binary GCD passes and the 32/64-step divides,
// all run one step per cycle in the one shared rfa_unit. One item at a time;
// in_stall is high from accept until the result is handed to the output register.
// Asynchronous active-low reset empties the block.
`timescale 1ns / 1ps
`include "rational_fraction_alu_macros.svh"

module rational_fraction_alu import rfa_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [1:0]  kind,
	input  logic signed [31:0] left_num,
	input  logic signed [31:0] left_den,
	input  logic signed [31:0] right_num,
	input  logic signed [31:0] right_den,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] res_num,
	output logic        [30:0] res_den,
	output logic        [1:0]  status,
	output logic               left_less,
	output logic               both_equal
);

	localparam logic [63:0] BOUND = 64'd1 << (WORD_BITS - 1);

	typedef enum logic [25:0] {
		S_IDLE = 26'h0000001,
		S_LG   = 26'h0000002,
		S_LDN  = 26'h0000004,
		S_LDD  = 26'h0000008,
		S_RG   = 26'h0000010,
		S_RDN  = 26'h0000020,
		S_RDD  = 26'h0000040,
		S_CM1  = 26'h0000080,
		S_CM2  = 26'h0000100,
		S_CMP  = 26'h0000200,
		S_AG   = 26'h0000400,
		S_AX   = 26'h0000800,
		S_AY   = 26'h0001000,
		S_AL   = 26'h0002000,
		S_AT1  = 26'h0004000,
		S_AT2  = 26'h0008000,
		S_ASUM = 26'h0010000,
		S_MN   = 26'h0020000,
		S_MD   = 26'h0040000,
		S_DN   = 26'h0080000,
		S_DD   = 26'h0100000,
		S_ZCHK = 26'h0200000,
		S_ZG   = 26'h0400000,
		S_ZN   = 26'h0800000,
		S_ZD   = 26'h1000000,
		S_FIN  = 26'h2000000
	} state_t;

	state_t      state_q;
	logic        issued_q;
	logic [1:0]  kind_q;
	logic        sa_q, sb_q;
	logic [31:0] pa_q, pb_q;
	logic [30:0] qa_q, qb_q;
	logic [63:0] g_q, t1_q, t2_q, nmag_q, dmag_q;
	logic        neg_q;
	logic [1:0]  err_q;
	logic        less_q, eq_q;

	logic        out_valid_q;
	logic [31:0] res_num_q;
	logic [30:0] res_den_q;
	logic [1:0]  status_q;
	logic        left_less_q, both_equal_q;

	unit_cmd_t   unit_cmd;
	unit_rsp_t   unit_rsp;
	logic [63:0] unit_opa, unit_opb, unit_res;
	logic        call, skip;

	logic [31:0] ln_mag, rn_mag;
	logic        bad_den, sbe, ovf, out_free;

	assign ln_mag  = left_num[31] ? 32'(-left_num) : left_num;
	assign rn_mag  = right_num[31] ? 32'(-right_num) : right_num;
	assign bad_den = left_den[31] || (left_den == '0) || right_den[31] || (right_den == '0);
	assign sbe     = sb_q ^ (kind_q == K_SUB);
	assign ovf     = (dmag_q > BOUND - 64'd1) ||
	                 (neg_q ? (nmag_q > BOUND) : (nmag_q > BOUND - 64'd1));
	assign out_free = !out_valid_q || !out_stall;

	// operand routing into the shared unit
	always_comb begin
		call     = 1'b1;
		unit_opa = '0;
		unit_opb = '0;
		unit_cmd.op   = UOP_MUL;
		unit_cmd.wide = 1'b0;
		case (state_q)
			S_LG:  begin unit_cmd.op = UOP_GCD; unit_opa = 64'(pa_q); unit_opb = 64'(qa_q); end
			S_LDN: begin unit_cmd.op = UOP_DIV; unit_opa = 64'(pa_q); unit_opb = g_q; end
			S_LDD: begin unit_cmd.op = UOP_DIV; unit_opa = 64'(qa_q); unit_opb = g_q; end
			S_RG:  begin unit_cmd.op = UOP_GCD; unit_opa = 64'(pb_q); unit_opb = 64'(qb_q); end
			S_RDN: begin unit_cmd.op = UOP_DIV; unit_opa = 64'(pb_q); unit_opb = g_q; end
			S_RDD: begin unit_cmd.op = UOP_DIV; unit_opa = 64'(qb_q); unit_opb = g_q; end
			S_CM1: begin unit_opa = 64'(pa_q); unit_opb = 64'(qb_q); end
			S_CM2: begin unit_opa = 64'(pb_q); unit_opb = 64'(qa_q); end
			S_AG:  begin unit_cmd.op = UOP_GCD; unit_opa = 64'(qa_q); unit_opb = 64'(qb_q); end
			S_AX:  begin unit_cmd.op = UOP_DIV; unit_opa = 64'(qb_q); unit_opb = g_q; end
			S_AY:  begin unit_cmd.op = UOP_DIV; unit_opa = 64'(qa_q); unit_opb = g_q; end
			S_AL:  begin unit_opa = t2_q; unit_opb = 64'(qb_q); end
			S_AT1: begin unit_opa = 64'(pa_q); unit_opb = t1_q; end
			S_AT2: begin unit_opa = 64'(pb_q); unit_opb = t2_q; end
			S_MN:  begin unit_opa = 64'(pa_q); unit_opb = 64'(pb_q); end
			S_MD:  begin unit_opa = 64'(qa_q); unit_opb = 64'(qb_q); end
			S_DN:  begin unit_opa = 64'(pa_q); unit_opb = 64'(qb_q); end
			S_DD:  begin unit_opa = 64'(qa_q); unit_opb = 64'(pb_q); end
			S_ZG: begin
				unit_cmd.op = UOP_GCD; unit_cmd.wide = 1'b1;
				unit_opa = nmag_q; unit_opb = dmag_q;
			end
			S_ZN: begin
				unit_cmd.op = UOP_DIV; unit_cmd.wide = 1'b1;
				unit_opa = nmag_q; unit_opb = g_q;
			end
			S_ZD: begin
				unit_cmd.op = UOP_DIV; unit_cmd.wide = 1'b1;
				unit_opa = dmag_q; unit_opb = g_q;
			end
			default: call = 1'b0;
		endcase
		// zero numerator: no GCD needed; the operand is set to 0/1
		skip = ((state_q == S_LG) && (pa_q == '0)) || ((state_q == S_RG) && (pb_q == '0));
		unit_cmd.start = call && !issued_q && !skip;
	end

	rfa_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (unit_cmd),
		.opa    (unit_opa),
		.opb    (unit_opb),
		.rsp    (unit_rsp),
		.result (unit_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issued_q     <= 1'b0;
			kind_q       <= '0;
			sa_q         <= 1'b0;
			sb_q         <= 1'b0;
			pa_q         <= '0;
			pb_q         <= '0;
			qa_q         <= '0;
			qb_q         <= '0;
			g_q          <= '0;
			t1_q         <= '0;
			t2_q         <= '0;
			nmag_q       <= '0;
			dmag_q       <= '0;
			neg_q        <= 1'b0;
			err_q        <= ST_OK;
			less_q       <= 1'b0;
			eq_q         <= 1'b0;
			out_valid_q  <= 1'b0;
			res_num_q    <= '0;
			res_den_q    <= '0;
			status_q     <= ST_OK;
			left_less_q  <= 1'b0;
			both_equal_q <= 1'b0;
		end else begin
			if (unit_cmd.start) begin
				issued_q <= 1'b1;
			end else if (unit_rsp.done) begin
				issued_q <= 1'b0;
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= kind;
						sa_q   <= left_num[31];
						sb_q   <= right_num[31];
						pa_q   <= ln_mag;
						pb_q   <= rn_mag;
						qa_q   <= left_den[30:0];
						qb_q   <= right_den[30:0];
						neg_q  <= 1'b0;
						less_q <= 1'b0;
						eq_q   <= 1'b0;
						err_q  <= bad_den ? ST_BAD_DEN : ST_OK;
						state_q <= bad_den ? S_FIN : S_LG;
					end
				end
				S_LG: begin
					if (skip) begin
						qa_q    <= 31'd1;
						sa_q    <= 1'b0;
						state_q <= S_RG;
					end else if (unit_rsp.done) begin
						g_q     <= unit_res;
						state_q <= S_LDN;
					end
				end
				S_LDN: if (unit_rsp.done) begin pa_q <= unit_res[31:0]; state_q <= S_LDD; end
				S_LDD: if (unit_rsp.done) begin qa_q <= unit_res[30:0]; state_q <= S_RG; end
				S_RG: begin
					if (skip) begin
						qb_q    <= 31'd1;
						sb_q    <= 1'b0;
						state_q <= S_CM1;
					end else if (unit_rsp.done) begin
						g_q     <= unit_res;
						state_q <= S_RDN;
					end
				end
				S_RDN: if (unit_rsp.done) begin pb_q <= unit_res[31:0]; state_q <= S_RDD; end
				S_RDD: if (unit_rsp.done) begin qb_q <= unit_res[30:0]; state_q <= S_CM1; end
				S_CM1: if (unit_rsp.done) begin t1_q <= unit_res; state_q <= S_CM2; end
				S_CM2: if (unit_rsp.done) begin t2_q <= unit_res; state_q <= S_CMP; end
				S_CMP: begin
					// a zero operand always carries a clear sign here
					less_q <= (sa_q != sb_q) ? sa_q : (sa_q ? (t1_q > t2_q) : (t1_q < t2_q));
					eq_q   <= (sa_q == sb_q) && (pa_q == pb_q) && (qa_q == qb_q);
					case (kind_q)
						K_ADD, K_SUB: state_q <= S_AG;
						K_MUL: state_q <= S_MN;
						K_DIV: begin
							if (pb_q == '0) begin
								err_q   <= ST_DIV_ZERO;
								state_q <= S_FIN;
							end else begin
								state_q <= S_DN;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				// sums over lcm = (qa/g)*qb
				S_AG:  if (unit_rsp.done) begin g_q <= unit_res; state_q <= S_AX; end
				S_AX:  if (unit_rsp.done) begin t1_q <= unit_res; state_q <= S_AY; end
				S_AY:  if (unit_rsp.done) begin t2_q <= unit_res; state_q <= S_AL; end
				S_AL:  if (unit_rsp.done) begin dmag_q <= unit_res; state_q <= S_AT1; end
				S_AT1: if (unit_rsp.done) begin t1_q <= unit_res; state_q <= S_AT2; end
				S_AT2: if (unit_rsp.done) begin t2_q <= unit_res; state_q <= S_ASUM; end
				S_ASUM: begin
					if (sa_q == sbe) begin
						nmag_q <= t1_q + t2_q;
						neg_q  <= sa_q;
					end else if (t1_q >= t2_q) begin
						nmag_q <= t1_q - t2_q;
						neg_q  <= sa_q;
					end else begin
						nmag_q <= t2_q - t1_q;
						neg_q  <= sbe;
					end
					state_q <= S_ZCHK;
				end
				S_MN: if (unit_rsp.done) begin
					nmag_q <= unit_res; neg_q <= sa_q ^ sb_q; state_q <= S_MD;
				end
				S_MD: if (unit_rsp.done) begin dmag_q <= unit_res; state_q <= S_ZCHK; end
				S_DN: if (unit_rsp.done) begin
					nmag_q <= unit_res; neg_q <= sa_q ^ sb_q; state_q <= S_DD;
				end
				S_DD: if (unit_rsp.done) begin dmag_q <= unit_res; state_q <= S_ZCHK; end
				S_ZCHK: begin
					if (nmag_q == '0) begin
						dmag_q  <= 64'd1;
						neg_q   <= 1'b0;
						state_q <= S_FIN;
					end else begin
						state_q <= S_ZG;
					end
				end
				S_ZG: if (unit_rsp.done) begin g_q <= unit_res; state_q <= S_ZN; end
				S_ZN: if (unit_rsp.done) begin nmag_q <= unit_res; state_q <= S_ZD; end
				S_ZD: if (unit_rsp.done) begin dmag_q <= unit_res; state_q <= S_FIN; end
				S_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						left_less_q  <= less_q;
						both_equal_q <= eq_q;
						if (err_q != ST_OK) begin
							status_q  <= err_q;
							res_num_q <= '0;
							res_den_q <= 31'd1;
						end else if (ovf) begin
							status_q  <= ST_OVERFLOW;
							res_num_q <= '0;
							res_den_q <= 31'd1;
						end else begin
							status_q  <= ST_OK;
							res_num_q <= neg_q ? (~nmag_q[31:0] + 32'd1) : nmag_q[31:0];
							res_den_q <= dmag_q[30:0];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign res_num    = res_num_q;
	assign res_den    = res_den_q;
	assign status     = status_q;
	assign left_less  = left_less_q;
	assign both_equal = both_equal_q;

	`RFA_ASSERT_IMP(a_bad_den_result, clk, arst_n, out_valid && status == ST_BAD_DEN, res_num == 0 && res_den == 1 && !left_less && !both_equal, "bad denominator item not cleared")
	`RFA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "block not busy after accepting an item")
	`RFA_ASSERT_IMP(a_unit_idle_when_free, clk, arst_n, !in_stall, !unit_rsp.busy, "shared unit still running while block is idle")
	`RFA_ASSERT_IMP(a_flags_exclusive, clk, arst_n, out_valid, !(left_less && both_equal), "less and equal flags both set")

endmodule

### tb/rational_fraction_alu_checker.sv
// Scoreboard for the rational fraction ALU: watches both channels, predicts each result.
// Depends on rfa_pkg for the operation and status codes.
`timescale 1ns / 1ps

module rational_fraction_alu_checker import rfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic        [1:0]  kind,
	input  logic signed [31:0] left_num,
	input  logic signed [31:0] left_den,
	input  logic signed [31:0] right_num,
	input  logic signed [31:0] right_den,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] res_num,
	input  logic        [30:0] res_den,
	input  logic        [1:0]  status,
	input  logic               left_less,
	input  logic               both_equal,
	output int                 fail_count,
	output int                 pending
);
	typedef struct packed {
		logic signed [31:0] num;
		logic        [30:0] den;
		logic        [1:0]  st;
		logic               less;
		logic               eq;
	} frac_result_t;

	frac_result_t expected_q[$];

	function automatic logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
		logic [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// signed value in lowest terms; den > 0
	function automatic void lowest(input logic signed [127:0] n, input logic signed [127:0] d,
			output logic signed [127:0] rn, output logic signed [127:0] rd);
		logic [127:0] mn, md, g, t;
		logic neg;
		neg = (n < 0) != (d < 0);
		mn = n < 0 ? -n : n;
		md = d < 0 ? -d : d;
		if (mn == 0) begin
			rn = 0;
			rd = 1;
			return;
		end
		g = mn;
		t = md;
		while (t != 0) begin
			logic [127:0] r;
			r = g % t;
			g = t;
			t = r;
		end
		rn = neg ? -$signed(mn / g) : $signed(mn / g);
		rd = md / g;
	endfunction

	function automatic frac_result_t predict_fraction(logic [1:0] k, logic signed [31:0] ln,
			logic signed [31:0] ld, logic signed [31:0] rn, logic signed [31:0] rd);
		frac_result_t r;
		logic signed [127:0] pa, qa, pb, qb, n, d, l, on, od;
		r = '{num: 0, den: 1, st: ST_OK, less: 0, eq: 0};
		if (ld <= 0 || rd <= 0) begin
			r.st = ST_BAD_DEN;
			return r;
		end
		lowest(ln, ld, pa, qa);
		lowest(rn, rd, pb, qb);
		r.less = pa * qb < pb * qa;
		r.eq = pa == pb && qa == qb;
		n = 0;
		d = 1;
		case (k)
			K_ADD, K_SUB: begin
				l = (qa / euclid(qa[63:0], qb[63:0])) * qb;
				n = (k == K_ADD) ? pa * (l / qa) + pb * (l / qb) : pa * (l / qa) - pb * (l / qb);
				d = l;
			end
			K_MUL: begin
				n = pa * pb;
				d = qa * qb;
			end
			default: begin
				if (pb == 0) r.st = ST_DIV_ZERO;
				n = pa * qb;
				d = qa * pb;
			end
		endcase
		if (r.st == ST_OK) begin
			lowest(n, d, on, od);
			if (od > 128'sh7FFFFFFF || on > 128'sh7FFFFFFF || on < -128'sh80000000)
				r.st = ST_OVERFLOW;
			else begin
				r.num = on[31:0];
				r.den = od[30:0];
			end
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		frac_result_t e;
		if (!arst_n) begin
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_q.push_back(predict_fraction(kind, left_num, left_den,
					right_num, right_den));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result item with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (res_num !== e.num || res_den !== e.den || status !== e.st ||
							left_less !== e.less || both_equal !== e.eq) begin
						if (res_num !== e.num) $error("res_num exp %0d got %0d", e.num, res_num);
						if (res_den !== e.den) $error("res_den exp %0d got %0d", e.den, res_den);
						if (status !== e.st) $error("status exp %0d got %0d", e.st, status);
						if (left_less !== e.less)
							$error("left_less exp %0d got %0d", e.less, left_less);
						if (both_equal !== e.eq)
							$error("both_equal exp %0d got %0d", e.eq, both_equal);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

### tb/rational_fraction_alu_test.sv
// Testbench top for the rational fraction ALU: directed and random fraction items.
// Depends on rfa_pkg, rational_fraction_alu and rational_fraction_alu_checker.
`timescale 1ns / 1ps

module rational_fraction_alu_test import rfa_pkg::*;;
	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0;
	logic [1:0] kind = K_ADD;
	logic signed [31:0] left_num = 0, left_den = 1, right_num = 0, right_den = 1;
	logic in_stall, out_valid, left_less, both_equal;
	logic signed [31:0] res_num;
	logic [30:0] res_den;
	logic [1:0] status;
	int fail_count, pending;
	logic hold_off = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	rational_fraction_alu u_dut (.*);
	rational_fraction_alu_checker u_chk (.*);

	function automatic logic signed [31:0] pick_value(bit den_field);
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return den_field ? 32'sd1 : 32'sd0;
			3: return $urandom();
			4: return 32'(-$signed({1'b0, $urandom_range(1, 1000)}));
			default: return $urandom_range(1, 1 << $urandom_range(1, 20)) * $urandom_range(1, 12);
		endcase
	endfunction

	task automatic send_item(logic [1:0] k, logic signed [31:0] ln, logic signed [31:0] ld,
			logic signed [31:0] rn, logic signed [31:0] rd);
		in_valid <= 1;
		kind <= k;
		left_num <= ln;
		left_den <= ld;
		right_num <= rn;
		right_den <= rd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// receiver stall pattern, with one long hold-off while items keep coming
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) out_stall <= 1;
			else begin
				mode = $urandom_range(0, 3);
				out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
			end
		end
	end

	initial begin
		@(posedge arst_n);
		repeat (3000) @(posedge clk);
		hold_off = 1;
		repeat (5000) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		#200_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int burst, lden, rden, gap;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: each operation, sign and range extremes, bad dens, zero divide, overflow
		send_item(K_ADD, 1, 2, 1, 3);
		send_item(K_SUB, 1, 2, 1, 2);
		send_item(K_MUL, -4, 6, 3, 9);
		send_item(K_DIV, 2, 3, -4, 5);
		send_item(K_DIV, 5, 7, 0, 3);
		send_item(K_ADD, 1, 0, 1, 1);
		send_item(K_MUL, 1, 1, 1, -5);
		send_item(K_SUB, 0, 32'sh80000000, 0, 1);
		send_item(K_ADD, 32'sh7FFFFFFF, 1, 32'sh7FFFFFFF, 1);
		send_item(K_SUB, 32'sh80000000, 1, 1, 1);
		send_item(K_MUL, 32'sh80000000, 1, 32'sh80000000, 1);
		send_item(K_DIV, 32'sh80000000, 1, -1, 1);
		send_item(K_DIV, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
		send_item(K_ADD, 1, 32'sh7FFFFFFF, 1, 32'sh7FFFFFFE);
		send_item(K_MUL, 0, 5, 32'sh80000000, 3);
		send_item(K_SUB, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_item(K_DIV, -6, 4, -3, 2);
		send_item(K_ADD, -1, 2, 1, 2);
		send_item(K_MUL, 32'shFFFFFFFF, 32'sh7FFFFFFF, 32'shFFFFFFFF, 32'sh55555555);
		for (int i = 0; i < 1950; i++) begin
			lden = pick_value(1);
			rden = pick_value(1);
			// mostly well-formed denominators
			if ($urandom_range(0, 7) != 0) begin
				if (lden <= 0) lden = $urandom_range(1, 30000);
				if (rden <= 0) rden = $urandom_range(1, 30000);
			end
			send_item($urandom_range(0, 3), pick_value(0), lden, pick_value(0), rden);
			if (burst == 0) begin
				burst = $urandom_range(0, 8);
				gap = $urandom_range(0, 3) * $urandom_range(0, 60);
				if (gap != 0) begin
					in_valid <= 0;
					repeat (gap) @(posedge clk);
				end
			end else burst--;
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (fail_count == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
